>>> src/res_pkg.sv
package res_pkg;

    // sample and count sizing
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_LOG2  = 20;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int SUM_W  = 2 * SAMPLE_BITS + COUNT_LOG2;
    localparam int CNT_W  = COUNT_LOG2 + 1;
    localparam int MSE_W  = 2 * SAMPLE_BITS;
    localparam int ROOT_W = SAMPLE_BITS;

    // shared subtractor covers both the divide and the root steps
    localparam int DIV_OP_W  = CNT_W + 1;
    localparam int ROOT_OP_W = ROOT_W + 3;
    localparam int UNIT_W    = ((DIV_OP_W > ROOT_OP_W) ? DIV_OP_W : ROOT_OP_W) + 1;

    localparam int STEP_W = $clog2(MSE_W);

    localparam logic [CNT_W-1:0] COUNT_BOUND = CNT_W'(1) << COUNT_LOG2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_ACC,
        ST_DIV,
        ST_ROOT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ref_sample;
        logic signed [SAMPLE_BITS-1:0] test_sample;
        logic                          last_item;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0]              sum_sq_err;
        logic [CNT_W-1:0]              sample_count;
        logic [MSE_W-1:0]              mean_sq_err;
        logic [ROOT_W-1:0]             root_mean_sq_err;
        logic [SAMPLE_BITS-1:0]        max_abs_err;
        logic signed [SAMPLE_BITS-1:0] ref_min;
        logic signed [SAMPLE_BITS-1:0] ref_max;
        logic                          identical;
        logic                          count_overflow;
    } t_out_item;

    typedef struct packed {
        logic in_ready;
        logic do_diff;
        logic do_sq;
        logic do_acc;
        logic do_div;
        logic do_root;
        logic do_fin;
    } t_ctrl;

endpackage

>>> src/reconstruction_error_stats.sv
// Streaming error statistics between a reference and a reconstructed array. Each
// request carries one sample pair; the block keeps the sum of squared differences,
// the peak absolute difference, the reference minimum and maximum, a pair count that
// saturates at 2^COUNT_LOG2 (raising count_overflow) and an all-equal flag. A pair
// goes through difference, square and accumulate steps, during which o_in_ready is
// low, so a new pair is accepted only once the previous one is through.
// The pair marked last_item also runs a restoring divide for the mean squared error
// and a digit-by-digit square root on one shared subtractor, then loads the result
// register, waiting if the previous result has not yet been taken. The statistics
// then clear for the next array. A finished result waits in its own register while
// new pairs flow.
module reconstruction_error_stats (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  res_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output res_pkg::t_out_item o_out_data
);
    import res_pkg::*;

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;

    // captured request
    logic signed [SAMPLE_BITS-1:0] r_ref;
    logic signed [SAMPLE_BITS-1:0] r_test;
    logic                          r_last;

    // per-pair datapath
    logic [SAMPLE_BITS-1:0] r_ad;
    logic [SQ_W-1:0]        r_sq;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;

    // accumulated statistics
    logic [SUM_W-1:0]              r_sum;
    logic [SUM_W-1:0]              n_sum;
    logic [SAMPLE_BITS-1:0]        r_peak;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic [CNT_W-1:0]              r_count;
    logic                          r_same;
    logic                          r_ovf;
    logic                          at_bound;

    // divide and root
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_rem;
    logic [MSE_W-1:0]   r_quo;
    logic [MSE_W-1:0]   r_mse;
    logic [MSE_W-1:0]   r_rad;
    logic [ROOT_W:0]    r_srem;
    logic [ROOT_W-1:0]  r_root;
    logic [DIV_OP_W-1:0]  div_a;
    logic [ROOT_OP_W-1:0] root_a;
    logic [ROOT_W+1:0]    root_b;
    logic [UNIT_W-1:0]  unit_a;
    logic [UNIT_W-1:0]  unit_b;
    logic [UNIT_W-1:0]  unit_d;
    logic               unit_ge;
    logic [MSE_W-1:0]   quo_next;

    // result register
    t_out_item r_out;
    logic      r_out_valid;
    logic      out_free;

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(MSE_W - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

    assign out_free = !r_out_valid || i_out_ready;
    assign at_bound = r_count[COUNT_LOG2];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: n_state = ST_SQ;
            ST_SQ:   n_state = ST_ACC;
            ST_ACC: begin
                n_state = r_last ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_step == ROOT_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE: ctrl.in_ready = 1'b1;
            ST_DIFF: ctrl.do_diff  = 1'b1;
            ST_SQ:   ctrl.do_sq    = 1'b1;
            ST_ACC:  ctrl.do_acc   = 1'b1;
            ST_DIV:  ctrl.do_div   = 1'b1;
            ST_ROOT: ctrl.do_root  = 1'b1;
            ST_FIN:  ctrl.do_fin   = out_free;
            default: ctrl = '0;
        endcase
    end

    assign o_in_ready = ctrl.in_ready;

    // difference and magnitude
    assign diff     = DIFF_W'(r_ref) - DIFF_W'(r_test);
    assign diff_abs = diff[DIFF_W-1] ? (-diff) : diff;

    // pairs past the bound do not add to the sum
    assign n_sum = at_bound ? r_sum : (r_sum + SUM_W'(r_sq));

    // shared subtract and compare unit
    assign div_a  = {r_rem, r_quo[MSE_W-1]};
    assign root_a = {r_srem, r_rad[MSE_W-1:MSE_W-2]};
    assign root_b = {r_root, 2'b01};

    always_comb begin
        if (ctrl.do_root) begin
            unit_a = UNIT_W'(root_a);
            unit_b = UNIT_W'(root_b);
        end else begin
            unit_a = UNIT_W'(div_a);
            unit_b = UNIT_W'(r_count);
        end
    end

    assign unit_d   = unit_a - unit_b;
    assign unit_ge  = !unit_d[UNIT_W-1];
    assign quo_next = {r_quo[MSE_W-2:0], unit_ge};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture and per-pair pipeline
    always_ff @(posedge i_clk) begin
        if (ctrl.in_ready && i_in_valid) begin
            r_ref  <= i_in_data.ref_sample;
            r_test <= i_in_data.test_sample;
            r_last <= i_in_data.last_item;
        end
        if (ctrl.do_diff) begin
            r_ad <= diff_abs[SAMPLE_BITS-1:0];
        end
        if (ctrl.do_sq) begin
            r_sq <= SQ_W'(r_ad) * SQ_W'(r_ad);
        end
    end

    // statistics, cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctrl.do_fin) begin
            r_sum   <= '0;
            r_peak  <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_count <= '0;
            r_same  <= 1'b1;
            r_ovf   <= 1'b0;
        end else begin
            if (ctrl.do_diff) begin
                if (r_count == '0) begin
                    r_min <= r_ref;
                    r_max <= r_ref;
                end else begin
                    if (r_ref < r_min) begin
                        r_min <= r_ref;
                    end
                    if (r_ref > r_max) begin
                        r_max <= r_ref;
                    end
                end
                if (diff_abs[SAMPLE_BITS-1:0] > r_peak) begin
                    r_peak <= diff_abs[SAMPLE_BITS-1:0];
                end
                if (diff != '0) begin
                    r_same <= 1'b0;
                end
            end
            if (ctrl.do_acc) begin
                r_sum <= n_sum;
                if (at_bound) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // divide then square root, one step per cycle
    always_ff @(posedge i_clk) begin
        if (ctrl.do_acc) begin
            // quotient fits MSE_W bits, so the top of the sum seeds the remainder
            r_rem  <= CNT_W'(n_sum[SUM_W-1:MSE_W]);
            r_quo  <= n_sum[MSE_W-1:0];
            r_step <= '0;
        end
        if (ctrl.do_div) begin
            r_rem  <= unit_ge ? unit_d[CNT_W-1:0] : div_a[CNT_W-1:0];
            r_quo  <= quo_next;
            if (r_step == DIV_LAST) begin
                r_mse  <= quo_next;
                r_rad  <= quo_next;
                r_srem <= '0;
                r_root <= '0;
                r_step <= '0;
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
        end
        if (ctrl.do_root) begin
            r_srem <= unit_ge ? unit_d[ROOT_W:0] : root_a[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], unit_ge};
            r_rad  <= {r_rad[MSE_W-3:0], 2'b00};
            r_step <= r_step + STEP_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.do_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.do_fin) begin
            r_out.sum_sq_err       <= r_sum;
            r_out.sample_count     <= r_count;
            r_out.mean_sq_err      <= r_mse;
            r_out.root_mean_sq_err <= r_root;
            r_out.max_abs_err      <= r_peak;
            r_out.ref_min          <= r_min;
            r_out.ref_max          <= r_max;
            r_out.identical        <= r_same;
            r_out.count_overflow   <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // count never passes its bound
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BOUND)
        else $error("pair count beyond bound");

    // overflow only reported with a saturated count
    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.count_overflow |->
            o_out_data.sample_count == COUNT_BOUND)
        else $error("overflow without saturated count");

    // root is the floor square root of the mean
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((2*MSE_W+2)'(o_out_data.root_mean_sq_err) *
             (2*MSE_W+2)'(o_out_data.root_mean_sq_err)
                <= (2*MSE_W+2)'(o_out_data.mean_sq_err)) &&
            (((2*MSE_W+2)'(o_out_data.root_mean_sq_err) + (2*MSE_W+2)'(1)) *
             ((2*MSE_W+2)'(o_out_data.root_mean_sq_err) + (2*MSE_W+2)'(1))
                > (2*MSE_W+2)'(o_out_data.mean_sq_err)))
        else $error("root does not match mean");

    // equal arrays carry no error
    a_identical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.identical |->
            o_out_data.max_abs_err == '0 && o_out_data.sum_sq_err == '0)
        else $error("identical flag with nonzero error");

endmodule
